>>> design/vmt_pkg.sv
// ----------------------------------------------------------------------------
// vmt_pkg: shared types and constants of the VM command line tokenizer
// Character codes, keyword tables, word and result records, and the helper
// functions for appending a character and looking up keywords.
// ----------------------------------------------------------------------------
package vmt_pkg;

  localparam int LINE_BITS_DEFAULT = 20;
  localparam int MAX_KEY_CHARS     = 8;
  localparam int LINE_NUM_W        = 20;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Keyword codes
  localparam int         INS_KEYS    = 17;
  localparam int         SEG_KEYS    = 8;
  localparam logic [4:0] INS_INVALID = 5'd17;
  localparam logic [3:0] SEG_INVALID = 4'd8;

  // Keyword text, right-aligned: the last character sits in the low byte,
  // the first one in byte klen-1
  localparam logic [63:0] INS_TEXT [INS_KEYS] = '{
    "push", "pop", "add", "sub", "neg", "eq", "gt", "lt", "and", "or",
    "not", "label", "function", "goto", "if-goto", "return", "call"
  };
  localparam logic [3:0] INS_LEN [INS_KEYS] = '{
    4'd4, 4'd3, 4'd3, 4'd3, 4'd3, 4'd2, 4'd2, 4'd2, 4'd3, 4'd2,
    4'd3, 4'd5, 4'd8, 4'd4, 4'd7, 4'd6, 4'd4
  };
  localparam logic [63:0] SEG_TEXT [SEG_KEYS] = '{
    "constant", "static", "local", "argument", "pointer", "this", "that", "temp"
  };
  localparam logic [3:0] SEG_LEN [SEG_KEYS] = '{
    4'd8, 4'd6, 4'd5, 4'd8, 4'd7, 4'd4, 4'd4, 4'd4
  };

  // Word being collected; byte i of chars holds character i
  typedef struct packed {
    logic [63:0] chars;
    logic [3:0]  len;
    logic [15:0] acc;
    logic        all_digits;
  } word_t;

  localparam word_t WORD_CLEAR = '{chars: 64'd0, len: 4'd0, acc: 16'd0, all_digits: 1'b1};

  // One result item
  typedef struct packed {
    logic                  has_word;
    logic [1:0]            word_position;
    logic [3:0]            word_length;
    logic [4:0]            instruction_code;
    logic [3:0]            segment_code;
    logic [15:0]           number_value;
    logic                  is_number;
    logic                  name_ok;
    logic [LINE_NUM_W-1:0] line_number;
    logic                  line_end;
  } result_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Add one character to the word; length saturates one past the buffer
  function automatic word_t append_char(word_t w, logic [7:0] c);
    word_t       r;
    logic [15:0] d;
    r = w;
    d = {12'd0, 4'(c - CH_ZERO)};
    if (w.len < 4'(MAX_KEY_CHARS)) begin
      r.chars[{w.len[2:0], 3'b000} +: 8] = c;
    end
    if (w.len < 4'(MAX_KEY_CHARS + 1)) begin
      r.len = w.len + 4'd1;
    end
    if (is_digit(c)) begin
      r.acc = (w.acc << 3) + (w.acc << 1) + d;
    end else begin
      r.all_digits = 1'b0;
    end
    return r;
  endfunction

  // Bytes beyond the length are zero, so length plus leading bytes decide
  function automatic logic key_match(logic [63:0] chars, logic [3:0] len,
                                     logic [63:0] text, logic [3:0] klen);
    logic m;
    m = (len == klen);
    for (int i = 0; i < MAX_KEY_CHARS; i++) begin
      if (4'(i) < klen) begin
        m = m && (chars[8*i +: 8] == text[8*(int'(klen) - 1 - i) +: 8]);
      end
    end
    return m;
  endfunction

  function automatic logic [4:0] ins_lookup(logic [63:0] chars, logic [3:0] len);
    logic [4:0] code;
    code = INS_INVALID;
    for (int k = INS_KEYS - 1; k >= 0; k--) begin
      if (key_match(chars, len, INS_TEXT[k], INS_LEN[k])) begin
        code = 5'(k);
      end
    end
    return code;
  endfunction

  function automatic logic [3:0] seg_lookup(logic [63:0] chars, logic [3:0] len);
    logic [3:0] code;
    code = SEG_INVALID;
    for (int k = SEG_KEYS - 1; k >= 0; k--) begin
      if (key_match(chars, len, SEG_TEXT[k], SEG_LEN[k])) begin
        code = 4'(k);
      end
    end
    return code;
  endfunction

endpackage

>>> design/vmt_in_if.sv
// ----------------------------------------------------------------------------
// vmt_in_if: character channel into the tokenizer
// One request carries a raw character and the end-of-text flag.
// ----------------------------------------------------------------------------
interface vmt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_text;

  modport source (output valid, output char_byte, output end_of_text, input ready);
  modport sink   (input valid, input char_byte, input end_of_text, output ready);
endinterface

>>> design/vmt_out_if.sv
// ----------------------------------------------------------------------------
// vmt_out_if: token channel out of the tokenizer
// One request carries one finished word or a bare line end.
// ----------------------------------------------------------------------------
interface vmt_out_if;
  logic             valid;
  logic             ready;
  vmt_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/vm_command_line_tokenizer.sv
// ----------------------------------------------------------------------------
// vm_command_line_tokenizer: streaming tokenizer for stack-VM program text
// Splits characters into words, drops comments, numbers lines and looks up
// instruction and segment keywords for each finished word.
// ----------------------------------------------------------------------------
// One character is taken every cycle while the skid stage is empty; its token,
// if any, is registered (skid stage on a stall). All per-character work (up to
// two appends, keyword compare of the eight-byte buffer, result assembly) is a
// single combinational pass from the tokenizer state to the output register.
// An output register plus a one-entry skid stage sit on the result side, so a
// stalled consumer holds input back only after two results are waiting.
module vm_command_line_tokenizer #(
  parameter int LINE_BITS = vmt_pkg::LINE_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  vmt_in_if.sink     cmd_in,
  vmt_out_if.source  tok_out
);

  // Tokenizer state
  vmt_pkg::word_t       word, word_next;
  logic                 slash_pending, slash_pending_next;
  logic                 in_comment, in_comment_next;
  logic [1:0]           words_in_line, words_in_line_next;
  logic [LINE_BITS-1:0] line_count, line_count_next;

  // Output register and skid stage
  logic                 out_valid, skid_valid;
  vmt_pkg::result_t     out_data, skid_data;

  // Per-character decode
  logic [7:0]           c;
  logic                 eot, is_sep, is_nl, is_sl;
  logic                 comment_start, plain, app_c, sp_mid;
  logic                 word_done, line_done, has_w, emit, fire;
  vmt_pkg::word_t       w1, w2;
  logic [LINE_BITS-1:0] line_inc;
  logic [31:0]          line_wide;
  vmt_pkg::result_t     res;

  assign fire         = cmd_in.valid && cmd_in.ready;
  assign cmd_in.ready = !skid_valid;

  // Character handling and result assembly
  always_comb begin
    c   = cmd_in.char_byte;
    eot = cmd_in.end_of_text;
    is_sep = (c == vmt_pkg::CH_SPACE) || (c == vmt_pkg::CH_TAB) ||
             (c == vmt_pkg::CH_NUL);
    is_nl  = (c == vmt_pkg::CH_NL);
    is_sl  = (c == vmt_pkg::CH_SLASH);

    comment_start = !in_comment && slash_pending && is_sl;
    plain         = !in_comment && !comment_start;

    // pending slash joins the word first
    w1 = (plain && slash_pending) ? vmt_pkg::append_char(word, vmt_pkg::CH_SLASH)
                                  : word;
    app_c  = plain && !is_sep && !is_nl && !is_sl;
    sp_mid = plain && is_sl;
    // then the character itself, or a slash left pending at end of text
    if (app_c) begin
      w2 = vmt_pkg::append_char(w1, c);
    end else if (eot && sp_mid) begin
      w2 = vmt_pkg::append_char(w1, vmt_pkg::CH_SLASH);
    end else begin
      w2 = w1;
    end

    word_done = comment_start || (plain && (is_sep || is_nl)) || eot;
    line_done = is_nl || eot;
    has_w     = (w2.len != 4'd0);
    emit      = line_done || (word_done && has_w);

    line_inc  = line_count + LINE_BITS'(1);
    line_wide = 32'(line_inc);

    res                  = '0;
    res.instruction_code = vmt_pkg::INS_INVALID;
    res.segment_code     = vmt_pkg::SEG_INVALID;
    res.line_number      = line_wide[vmt_pkg::LINE_NUM_W-1:0];
    res.line_end         = line_done;
    if (has_w) begin
      res.has_word         = 1'b1;
      res.word_position    = words_in_line;
      res.word_length      = w2.len;
      res.instruction_code = vmt_pkg::ins_lookup(w2.chars, w2.len);
      res.segment_code     = vmt_pkg::seg_lookup(w2.chars, w2.len);
      res.number_value     = w2.all_digits ? w2.acc : 16'd0;
      res.is_number        = w2.all_digits;
      res.name_ok          = !vmt_pkg::is_digit(w2.chars[7:0]);
    end

    // next state
    word_next          = (word_done && has_w) ? vmt_pkg::WORD_CLEAR : w2;
    slash_pending_next = eot ? 1'b0 : sp_mid;
    if (line_done) begin
      in_comment_next = 1'b0;
    end else begin
      in_comment_next = in_comment || comment_start;
    end
    words_in_line_next = words_in_line;
    if (word_done && has_w && (words_in_line != 2'd3)) begin
      words_in_line_next = words_in_line + 2'd1;
    end
    line_count_next = line_count;
    if (line_done) begin
      words_in_line_next = 2'd0;
      line_count_next    = line_inc;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      word          <= vmt_pkg::WORD_CLEAR;
      slash_pending <= 1'b0;
      in_comment    <= 1'b0;
      words_in_line <= 2'd0;
      line_count    <= '0;
    end else if (fire) begin
      word          <= word_next;
      slash_pending <= slash_pending_next;
      in_comment    <= in_comment_next;
      words_in_line <= words_in_line_next;
      line_count    <= line_count_next;
    end
  end

  // Output register and skid: valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || tok_out.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= fire && emit;
      end
    end else if (fire && emit) begin
      skid_valid <= 1'b1;
    end
  end

  // Output register and skid: payload
  always_ff @(posedge clk) begin
    if (!out_valid || tok_out.ready) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else begin
        out_data <= res;
      end
    end else if (fire && emit) begin
      skid_data <= res;
    end
  end

  assign tok_out.valid = out_valid;
  assign tok_out.data  = out_data;

  // Checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds a request while output register is empty");

  a_comment_no_slash: assert property (@(posedge clk) disable iff (rst)
    !(slash_pending && in_comment))
    else $error("slash pending inside a comment");

  a_empty_word_clean: assert property (@(posedge clk) disable iff (rst)
    (word.len == 4'd0) |-> ((word.chars == 64'd0) && word.all_digits &&
                            (word.acc == 16'd0)))
    else $error("empty word buffer not clear");

  a_line_end_resets_pos: assert property (@(posedge clk) disable iff (rst)
    (fire && line_done) |=> (words_in_line == 2'd0))
    else $error("word position not reset after line end");

endmodule

>>> tb/sv/vm_command_line_tokenizer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vm_command_line_tokenizer_checker: token predictor and scoreboard
// Watches both channels. Every character request runs through a private
// tokenizer model that queues the token it should produce. Every token
// request is compared field by field with the oldest queued token.
// ----------------------------------------------------------------------------
module vm_command_line_tokenizer_checker #(
  parameter int LINE_BITS = vmt_pkg::LINE_BITS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  vmt_in_if    cmd_in,
  vmt_out_if   tok_out,
  output int   fail_count,
  output int   pending_count
);

  // Keyword spellings, indexed by their codes
  string ins_name [vmt_pkg::INS_KEYS] = '{
    "push", "pop", "add", "sub", "neg", "eq", "gt", "lt", "and", "or",
    "not", "label", "function", "goto", "if-goto", "return", "call"
  };
  string seg_name [vmt_pkg::SEG_KEYS] = '{
    "constant", "static", "local", "argument", "pointer", "this", "that", "temp"
  };

  // Model state: word under collection, comment tracking, line bookkeeping
  logic [63:0]          buf_chars;
  logic [3:0]           buf_len;
  logic [15:0]          dec_value;
  logic                 digits_only;
  logic                 slash_seen;
  logic                 skipping;
  logic [1:0]           line_words;
  logic [LINE_BITS-1:0] lines_done;
  vmt_pkg::result_t     tok_expected [$];

  function automatic logic word_is(string key);
    if (key.len() != int'(buf_len)) return 1'b0;
    for (int i = 0; i < key.len(); i++) begin
      if (buf_chars[8*i +: 8] != key[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic clear_word();
    buf_chars   = '0;
    buf_len     = '0;
    dec_value   = '0;
    digits_only = 1'b1;
  endtask

  // Only the first eight characters are kept; length stops at nine
  task automatic take_char(logic [7:0] c);
    if (buf_len < 4'd8) buf_chars[8*buf_len +: 8] = c;
    if (buf_len < 4'd9) buf_len = buf_len + 4'd1;
    if (c >= vmt_pkg::CH_ZERO && c <= vmt_pkg::CH_NINE) begin
      dec_value = dec_value * 16'd10 + 16'(c) - 16'(vmt_pkg::CH_ZERO);
    end else begin
      digits_only = 1'b0;
    end
  endtask

  // Advance the model by one character and queue the token it gives, if any
  task automatic tokenize_char(logic [7:0] c, logic eot);
    logic                 word_done;
    logic                 line_done;
    logic [LINE_BITS-1:0] line_plus;
    logic [31:0]          line_wide;
    vmt_pkg::result_t     tok;
    word_done = 1'b0;
    line_done = 1'b0;
    if (skipping) begin
      if (c == vmt_pkg::CH_NL) line_done = 1'b1;
    end else if (slash_seen && c == vmt_pkg::CH_SLASH) begin
      // second slash: comment opens and the word so far is finished
      slash_seen = 1'b0;
      skipping   = 1'b1;
      word_done  = 1'b1;
    end else begin
      if (slash_seen) begin
        take_char(vmt_pkg::CH_SLASH);
        slash_seen = 1'b0;
      end
      if (c == vmt_pkg::CH_SPACE || c == vmt_pkg::CH_TAB || c == vmt_pkg::CH_NUL) begin
        word_done = 1'b1;
      end else if (c == vmt_pkg::CH_NL) begin
        word_done = 1'b1;
        line_done = 1'b1;
      end else if (c == vmt_pkg::CH_SLASH) begin
        slash_seen = 1'b1;
      end else begin
        take_char(c);
      end
    end
    // end of text: a held slash joins the word, then the line closes
    if (eot) begin
      if (slash_seen) begin
        take_char(vmt_pkg::CH_SLASH);
        slash_seen = 1'b0;
      end
      word_done = 1'b1;
      line_done = 1'b1;
    end
    if (line_done) skipping = 1'b0;

    if (line_done || (word_done && buf_len != 4'd0)) begin
      line_plus            = lines_done + LINE_BITS'(1);
      line_wide            = 32'(line_plus);
      tok                  = '0;
      tok.instruction_code = vmt_pkg::INS_INVALID;
      tok.segment_code     = vmt_pkg::SEG_INVALID;
      tok.line_number      = line_wide[vmt_pkg::LINE_NUM_W-1:0];
      tok.line_end         = line_done;
      if (buf_len != 4'd0) begin
        tok.has_word      = 1'b1;
        tok.word_position = line_words;
        tok.word_length   = buf_len;
        for (int k = 0; k < vmt_pkg::INS_KEYS; k++) begin
          if (word_is(ins_name[k])) tok.instruction_code = 5'(k);
        end
        for (int k = 0; k < vmt_pkg::SEG_KEYS; k++) begin
          if (word_is(seg_name[k])) tok.segment_code = 4'(k);
        end
        tok.number_value = digits_only ? dec_value : 16'd0;
        tok.is_number    = digits_only;
        tok.name_ok      = !(buf_chars[7:0] >= vmt_pkg::CH_ZERO &&
                             buf_chars[7:0] <= vmt_pkg::CH_NINE);
        if (line_words != 2'd3) line_words = line_words + 2'd1;
        clear_word();
      end
      if (line_done) begin
        line_words = '0;
        lines_done = lines_done + LINE_BITS'(1);
      end
      tok_expected.push_back(tok);
    end
  endtask

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endtask

  task automatic check_token();
    vmt_pkg::result_t want;
    vmt_pkg::result_t got;
    got = tok_out.data;
    if (tok_expected.size() == 0) begin
      $error("token request with nothing expected (line_number %0d)", got.line_number);
      fail_count++;
      return;
    end
    want = tok_expected.pop_front();
    check_field("has_word",         want.has_word,         got.has_word);
    check_field("word_position",    want.word_position,    got.word_position);
    check_field("word_length",      want.word_length,      got.word_length);
    check_field("instruction_code", want.instruction_code, got.instruction_code);
    check_field("segment_code",     want.segment_code,     got.segment_code);
    check_field("number_value",     want.number_value,     got.number_value);
    check_field("is_number",        want.is_number,        got.is_number);
    check_field("name_ok",          want.name_ok,          got.name_ok);
    check_field("line_number",      want.line_number,      got.line_number);
    check_field("line_end",         want.line_end,         got.line_end);
  endtask

  // Inputs are handled before outputs; a token never leaves on its own edge
  always @(posedge clk) begin
    if (rst) begin
      clear_word();
      slash_seen = 1'b0;
      skipping   = 1'b0;
      line_words = '0;
      lines_done = '0;
      tok_expected.delete();
      fail_count = 0;
    end else begin
      if (cmd_in.valid && cmd_in.ready) tokenize_char(cmd_in.char_byte, cmd_in.end_of_text);
      if (tok_out.valid && tok_out.ready) check_token();
    end
    pending_count = tok_expected.size();
  end

endmodule

>>> tb/sv/vm_command_line_tokenizer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vm_command_line_tokenizer_test: top of the tokenizer testbench
// Feeds a short directed text covering the corner cases, then random
// program lines (mostly well-formed commands, some noise), with random
// gaps on the character side and random stalls on the token side.
// ----------------------------------------------------------------------------
module vm_command_line_tokenizer_test;

  localparam int ITEM_TARGET = 625;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending_count;
  int   chars_sent;
  bit   idling_on;
  bit   drained_once;

  vmt_in_if  cmd_in ();
  vmt_out_if tok_out ();

  vm_command_line_tokenizer u_dut (
    .clk     (clk),
    .rst     (rst),
    .cmd_in  (cmd_in),
    .tok_out (tok_out)
  );

  vm_command_line_tokenizer_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cmd_in        (cmd_in),
    .tok_out       (tok_out),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // Word lists for random lines
  string ins_words [vmt_pkg::INS_KEYS] = '{
    "push", "pop", "add", "sub", "neg", "eq", "gt", "lt", "and", "or",
    "not", "label", "function", "goto", "if-goto", "return", "call"
  };
  string seg_words [vmt_pkg::SEG_KEYS] = '{
    "constant", "static", "local", "argument", "pointer", "this", "that", "temp"
  };
  string odd_words [14] = '{
    "pus", "pushh", "Push", "if-got", "if-goto1", "functions", "constan",
    "constants", "/", "a/b", "x7", "3d", "thisthat", "0"
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Token side: ready in random bursts while idling is on
  initial begin
    tok_out.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idling_on && $urandom_range(0, 2) == 0) begin
        tok_out.ready = 1'b0;
      end else begin
        tok_out.ready = 1'b1;
      end
      repeat ($urandom_range(0, 11)) @(negedge clk);
    end
  end

  // One character request, after an optional gap
  task automatic send_item(logic [7:0] c, logic eot);
    @(negedge clk);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      cmd_in.valid       = 1'b0;
      cmd_in.char_byte   = 8'($urandom);
      cmd_in.end_of_text = 1'($urandom);
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    cmd_in.valid       = 1'b1;
    cmd_in.char_byte   = c;
    cmd_in.end_of_text = eot;
    do @(posedge clk); while (!cmd_in.ready);
    chars_sent++;
  endtask

  task automatic send_text(string s, logic eot_last);
    for (int i = 0; i < s.len(); i++) begin
      send_item(s[i], eot_last && (i == s.len() - 1));
    end
  endtask

  // Stop sending and wait for every outstanding token
  task automatic wait_drained();
    @(negedge clk);
    cmd_in.valid = 1'b0;
    wait (pending_count == 0);
  endtask

  function automatic logic [7:0] pick_sep();
    case ($urandom_range(0, 5))
      4:       return vmt_pkg::CH_TAB;
      5:       return vmt_pkg::CH_NUL;
      default: return vmt_pkg::CH_SPACE;
    endcase
  endfunction

  task automatic send_seps();
    repeat (($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 1) send_item(pick_sep(), 1'b0);
  endtask

  function automatic string pick_keyword(bit segment);
    if ($urandom_range(0, 7) == 0) return odd_words[$urandom_range(0, 13)];
    if (segment) return seg_words[$urandom_range(0, vmt_pkg::SEG_KEYS - 1)];
    return ins_words[$urandom_range(0, vmt_pkg::INS_KEYS - 1)];
  endfunction

  // Short values mostly, some past 16 bits and some past the buffer length
  function automatic string number_text();
    case ($urandom_range(0, 3))
      0:       return $sformatf("%0d", $urandom_range(0, 9));
      1:       return $sformatf("%0d", $urandom_range(0, 65535));
      2:       return $sformatf("%0d", $urandom_range(65536, 99999999));
      default: return $sformatf("%0d%0d", $urandom, $urandom_range(0, 999));
    endcase
  endfunction

  // Raw bytes, biased towards the characters the tokenizer cares about
  task automatic send_noise(int n);
    logic [7:0] c;
    repeat (n) begin
      case ($urandom_range(0, 5))
        0:       c = vmt_pkg::CH_SLASH;
        1:       c = pick_sep();
        2:       c = vmt_pkg::CH_NL;
        3:       c = 8'($urandom_range(vmt_pkg::CH_ZERO, vmt_pkg::CH_NINE));
        default: c = 8'($urandom);
      endcase
      send_item(c, 1'b0);
    end
  endtask

  // Newline mostly; sometimes end of text on assorted characters
  task automatic finish_line();
    case ($urandom_range(0, 11))
      0:       send_item(vmt_pkg::CH_NL, 1'b1);
      1:       send_item(8'($urandom_range(8'h61, 8'h7A)), 1'b1);
      2:       send_item(vmt_pkg::CH_SLASH, 1'b1);
      3:       send_item(pick_sep(), 1'b1);
      default: send_item(vmt_pkg::CH_NL, 1'b0);
    endcase
  endtask

  task automatic send_line();
    int shape;
    int extra;
    shape = $urandom_range(0, 9);
    if (shape < 8) begin
      if ($urandom_range(0, 3) == 0) send_seps();
      send_text(pick_keyword(1'b0), 1'b0);
      if (shape < 6) begin
        send_seps();
        send_text(pick_keyword(1'b1), 1'b0);
        send_seps();
        send_text(number_text(), 1'b0);
      end
      // extra operands push the word position into saturation
      extra = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
      repeat (extra) begin
        send_seps();
        send_text(($urandom_range(0, 1) == 0) ? odd_words[$urandom_range(0, 13)] :
                  number_text(), 1'b0);
      end
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 1) == 0) send_seps();
        send_text("//", 1'b0);
        send_noise($urandom_range(0, 6));
      end else if ($urandom_range(0, 3) == 0) begin
        send_seps();
      end
    end else begin
      send_noise($urandom_range(1, 15));
    end
    finish_line();
  endtask

  initial begin
    rst                = 1'b1;
    cmd_in.valid       = 1'b0;
    cmd_in.char_byte   = 8'd0;
    cmd_in.end_of_text = 1'b0;
    idling_on          = 1'b1;
    drained_once       = 1'b0;
    chars_sent         = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed text: bare line end, value wrap, separators in a row,
    // top byte, lone slash, comment opening, long word, slash at end of text
    send_item(vmt_pkg::CH_NL, 1'b0);
    send_text("99999\t", 1'b0);
    send_item(vmt_pkg::CH_NUL, 1'b0);
    send_item(8'hFF, 1'b0);
    send_text("/b//c\n", 1'b0);
    send_text("functions ", 1'b0);
    send_text("p/", 1'b1);

    // random lines; a quiet stretch in the middle and another at the end
    while (chars_sent < ITEM_TARGET) begin
      idling_on = (chars_sent < 300 || chars_sent >= 380) && chars_sent < 540;
      if (!drained_once && chars_sent >= 180) begin
        wait_drained();
        drained_once = 1'b1;
      end
      send_line();
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
